@@ src/ptc_pkg.sv @@
// package for the piecewise linear thermo correction block
// widths, state encoding and divider request type; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ptc_pkg;

  localparam int unsigned ENTRIES         = 16;
  localparam int unsigned IDX_W           = $clog2(ENTRIES);
  localparam int unsigned SLOPE_FRAC_BITS = 16;
  localparam int unsigned TEMP_W          = 16;
  localparam int unsigned CORR_W          = 32;
  localparam int unsigned SLOPE_W         = 56;
  localparam int unsigned ROW_W           = SLOPE_W + CORR_W + TEMP_W;
  localparam int unsigned NUM_MAG_W       = CORR_W + SLOPE_FRAC_BITS;
  localparam int unsigned DIV_CNT_W       = $clog2(NUM_MAG_W + 1);
  localparam int unsigned GAP_W           = TEMP_W;
  localparam int unsigned MUL_LO_W        = SLOPE_W / 2;
  localparam int unsigned MUL_HI_W        = SLOPE_W - MUL_LO_W;
  localparam int unsigned PLO_W           = MUL_LO_W + GAP_W;
  localparam int unsigned PHI_W           = MUL_HI_W + GAP_W + 1;
  localparam int unsigned FULL_W          = SLOPE_W + GAP_W + 1;
  localparam int unsigned RES_W           = SLOPE_W + 2;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LD_RD,
    S_LD_CALC,
    S_LD_DIV,
    S_LD_WR,
    S_Q_LAST,
    S_Q_SCAN,
    S_Q_MUL_LO,
    S_Q_MUL_HI,
    S_Q_SUM,
    S_Q_DONE
  } state_e;

  typedef struct packed {
    logic                  start;
    logic                  negate;
    logic [NUM_MAG_W-1:0]  dividend;
    logic [TEMP_W-1:0]     divisor;
  } div_req_t;

endpackage

`default_nettype wire

@@ src/ptc_ram.sv @@
// breakpoint table: one row per entry holding slope, correction and temperature
// single write port, single read port with registered data; uses ptc_pkg
`timescale 1ns / 1ps
`default_nettype none

module ptc_ram
  import ptc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [IDX_W-1:0] waddr_i,
  input  wire logic [ROW_W-1:0] wdata_i,
  input  wire logic [IDX_W-1:0] raddr_i,
  output logic      [ROW_W-1:0] rdata_o
);

  logic [ROW_W-1:0] mem_q [ENTRIES];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ src/ptc_div.sv @@
// serial restoring divider for the segment slope, one quotient bit per cycle
// works on magnitudes and applies the sign at the end; uses ptc_pkg
`timescale 1ns / 1ps
`default_nettype none

module ptc_div
  import ptc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire div_req_t           req_i,
  output logic                    done_o,
  output logic      [SLOPE_W-1:0] quotient_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic                 neg_q, neg_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_MAG_W-1:0] quo_q, quo_d;
  logic [TEMP_W:0]      rem_q, rem_d;
  logic [TEMP_W-1:0]    dsr_q, dsr_d;
  logic [TEMP_W:0]      rem_sh;
  logic [TEMP_W+1:0]    trial;
  logic [SLOPE_W-1:0]   mag_ext;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    rem_sh = {rem_q[TEMP_W-1:0], quo_q[NUM_MAG_W-1]};
    trial  = {1'b0, rem_sh} - {2'b00, dsr_q};
    if (req_i.start) begin
      busy_d = 1'b1;
      neg_d  = req_i.negate;
      cnt_d  = '0;
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      if (!trial[TEMP_W+1]) begin
        rem_d = trial[TEMP_W:0];
        quo_d = {quo_q[NUM_MAG_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[NUM_MAG_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(NUM_MAG_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign mag_ext    = {{(SLOPE_W-NUM_MAG_W){1'b0}}, quo_q};
  assign quotient_o = neg_q ? (~mag_ext + 1'b1) : mag_ext;
  assign done_o     = done_q;

endmodule

`default_nettype wire

@@ src/piecewise_linear_thermo_correction_top.sv @@
// top level of the piecewise linear thermo correction block
// sequencer, interpolation datapath and output register; uses ptc_pkg, ptc_ram, ptc_div
//
// Usage: an input beat with command_i = 0 loads breakpoint entry_index_i with
// load_temp_i and load_correction_i and works out the slope to the entry below
// it; no result beat follows. A beat with command_i = 1 looks up query_temp_i
// and yields one result beat with correction_o, segment_o and clamped_o.
// One item is worked on at a time; in_ready_o is high only while the
// sequencer is idle. A load reads the entry below, then writes the row,
// waiting first on the serial divider when the slope needs it (one quotient
// bit per cycle over 48 bits). A query reads the table one row per cycle
// through the single read port: first the last breakpoint, then the rows
// scanned (up to 16); a split multiply, sum and saturation follow.
// Results sit in an output register; a new item is taken while a result still
// waits, and a finished query holds until that register frees up. The table
// holds nothing defined after reset; reset only returns the sequencer to idle
// and drops out_valid_o.
`timescale 1ns / 1ps
`default_nettype none

module piecewise_linear_thermo_correction_top
  import ptc_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic                     command_i,
  input  wire logic [3:0]               entry_index_i,
  input  wire logic signed [15:0]       load_temp_i,
  input  wire logic signed [31:0]       load_correction_i,
  input  wire logic signed [15:0]       query_temp_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic signed [31:0]            correction_o,
  output logic [3:0]                    segment_o,
  output logic                          clamped_o
);

  state_e state_q, state_d;

  logic [IDX_W-1:0]          idx_q, idx_d;
  logic signed [TEMP_W-1:0]  ltemp_q, ltemp_d;
  logic signed [CORR_W-1:0]  lcorr_q, lcorr_d;
  logic signed [TEMP_W-1:0]  t_q, t_d;
  logic                      clamp_q, clamp_d;
  logic [IDX_W-1:0]          seg_q, seg_d;
  logic [GAP_W-1:0]          gap_q, gap_d;
  logic [SLOPE_W-1:0]        slope_q, slope_d;
  logic signed [CORR_W-1:0]  corr_q, corr_d;
  logic [PLO_W-1:0]          plo_q, plo_d;
  logic signed [PHI_W-1:0]   phi_q, phi_d;
  logic signed [SLOPE_W-1:0] prod_q, prod_d;

  logic                      out_valid_q, out_valid_d;
  logic signed [CORR_W-1:0]  out_corr_q, out_corr_d;
  logic [IDX_W-1:0]          out_seg_q, out_seg_d;
  logic                      out_clamp_q, out_clamp_d;

  logic                      in_acc;
  logic                      out_free;
  logic                      ram_we;
  logic [IDX_W-1:0]          ram_raddr;
  logic [ROW_W-1:0]          ram_wdata;
  logic [ROW_W-1:0]          ram_rdata;
  logic signed [TEMP_W-1:0]  row_temp;
  logic signed [CORR_W-1:0]  row_corr;
  logic [SLOPE_W-1:0]        row_slope;
  logic signed [TEMP_W:0]    dt;
  logic signed [CORR_W:0]    dcorr;
  logic [CORR_W-1:0]         dcorr_mag;
  logic [TEMP_W-1:0]         dt_mag;
  logic signed [TEMP_W:0]    gap_full;
  logic signed [FULL_W-1:0]  full;
  logic signed [RES_W-1:0]   res;
  logic                      div_done;
  logic [SLOPE_W-1:0]        div_quo;
  div_req_t                  div_req;

  assign row_temp  = ram_rdata[TEMP_W-1:0];
  assign row_corr  = ram_rdata[TEMP_W +: CORR_W];
  assign row_slope = ram_rdata[TEMP_W+CORR_W +: SLOPE_W];

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // slope terms against the entry below
  assign dt        = {ltemp_q[TEMP_W-1], ltemp_q} - {row_temp[TEMP_W-1], row_temp};
  assign dcorr     = {lcorr_q[CORR_W-1], lcorr_q} - {row_corr[CORR_W-1], row_corr};
  assign dcorr_mag = dcorr[CORR_W] ? CORR_W'(-dcorr) : dcorr[CORR_W-1:0];
  assign dt_mag    = dt[TEMP_W] ? TEMP_W'(-dt) : dt[TEMP_W-1:0];
  assign gap_full  = {row_temp[TEMP_W-1], row_temp} - {t_q[TEMP_W-1], t_q};

  assign full = (FULL_W'(phi_q) <<< MUL_LO_W) + FULL_W'({1'b0, plo_q});
  assign res  = RES_W'(corr_q) - RES_W'(prod_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = (command_i == CMD_QUERY) ? S_Q_LAST : S_LD_RD;
        end
      end
      S_LD_RD:   state_d = S_LD_CALC;
      S_LD_CALC: begin
        if (idx_q == '0 || dt == '0) begin
          state_d = S_LD_WR;
        end else begin
          state_d = S_LD_DIV;
        end
      end
      S_LD_DIV: begin
        if (div_done) begin
          state_d = S_LD_WR;
        end
      end
      S_LD_WR:  state_d = S_IDLE;
      S_Q_LAST: state_d = S_Q_SCAN;
      S_Q_SCAN: begin
        if (!(seg_q != IDX_W'(ENTRIES - 1) && t_q > row_temp)) begin
          state_d = S_Q_MUL_LO;
        end
      end
      S_Q_MUL_LO: state_d = S_Q_MUL_HI;
      S_Q_MUL_HI: state_d = S_Q_SUM;
      S_Q_SUM:    state_d = S_Q_DONE;
      S_Q_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    idx_d       = idx_q;
    ltemp_d     = ltemp_q;
    lcorr_d     = lcorr_q;
    t_d         = t_q;
    clamp_d     = clamp_q;
    seg_d       = seg_q;
    gap_d       = gap_q;
    slope_d     = slope_q;
    corr_d      = corr_q;
    plo_d       = plo_q;
    phi_d       = phi_q;
    prod_d      = prod_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_corr_d  = out_corr_q;
    out_seg_d   = out_seg_q;
    out_clamp_d = out_clamp_q;
    ram_we      = 1'b0;
    ram_raddr   = idx_q - 1'b1;
    div_req     = '0;
    ram_wdata   = {slope_q, lcorr_q, ltemp_q};
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          idx_d   = entry_index_i;
          ltemp_d = load_temp_i;
          lcorr_d = load_correction_i;
          t_d     = query_temp_i;
        end
      end
      S_LD_RD: ram_raddr = idx_q - 1'b1;
      S_LD_CALC: begin
        slope_d          = '0;
        div_req.start    = (idx_q != '0) && (dt != '0);
        div_req.negate   = dcorr[CORR_W] ^ dt[TEMP_W];
        div_req.dividend = {dcorr_mag, {SLOPE_FRAC_BITS{1'b0}}};
        div_req.divisor  = dt_mag;
      end
      S_LD_DIV: begin
        if (div_done) begin
          slope_d = div_quo;
        end
      end
      S_LD_WR: ram_we = 1'b1;
      S_Q_LAST: begin
        ram_raddr = IDX_W'(ENTRIES - 1);
        clamp_d   = 1'b0;
      end
      S_Q_SCAN: begin
        // first pass here holds the last breakpoint, used to clamp
        ram_raddr = seg_q + 1'b1;
        if (seg_q != IDX_W'(ENTRIES - 1) && t_q > row_temp) begin
          seg_d = seg_q + 1'b1;
        end else begin
          gap_d   = gap_full[GAP_W-1:0];
          slope_d = row_slope;
          corr_d  = row_corr;
        end
      end
      S_Q_MUL_LO: plo_d = slope_q[MUL_LO_W-1:0] * gap_q;
      S_Q_MUL_HI: phi_d = $signed(slope_q[SLOPE_W-1:MUL_LO_W]) * $signed({1'b0, gap_q});
      S_Q_SUM:    prod_d = full[SLOPE_FRAC_BITS +: SLOPE_W];
      S_Q_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_seg_d   = seg_q;
          out_clamp_d = clamp_q;
          if (res > RES_W'(signed'(32'h7fffffff))) begin
            out_corr_d = 32'sh7fffffff;
          end else if (res < RES_W'(signed'(32'h80000000))) begin
            out_corr_d = 32'sh80000000;
          end else begin
            out_corr_d = res[CORR_W-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  // the clamp runs on the extra scan state entry: read 15 then restart at 0
  logic scan_first_q, scan_first_d;
  logic signed [TEMP_W-1:0] t_scan;

  always_comb begin
    scan_first_d = (state_q == S_Q_LAST);
    t_scan       = t_q;
  end

  // clamp and search start override
  logic signed [TEMP_W-1:0] t_fin;
  logic                     clamp_fin;
  logic [IDX_W-1:0]         seg_fin;
  logic [IDX_W-1:0]         raddr_fin;
  logic                     scan_hold;

  always_comb begin
    t_fin     = t_d;
    clamp_fin = clamp_d;
    seg_fin   = seg_d;
    raddr_fin = ram_raddr;
    scan_hold = 1'b0;
    if (state_q == S_Q_SCAN && scan_first_q) begin
      scan_hold = 1'b1;
      if (t_scan > row_temp) begin
        t_fin     = row_temp;
        clamp_fin = 1'b1;
      end
      seg_fin   = '0;
      raddr_fin = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      scan_first_q <= 1'b0;
    end else begin
      state_q      <= scan_hold ? S_Q_SCAN : state_d;
      out_valid_q  <= out_valid_d;
      scan_first_q <= scan_first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    ltemp_q     <= ltemp_d;
    lcorr_q     <= lcorr_d;
    t_q         <= t_fin;
    clamp_q     <= clamp_fin;
    seg_q       <= seg_fin;
    gap_q       <= gap_d;
    slope_q     <= slope_d;
    corr_q      <= corr_d;
    plo_q       <= plo_d;
    phi_q       <= phi_d;
    prod_q      <= prod_d;
    out_corr_q  <= out_corr_d;
    out_seg_q   <= out_seg_d;
    out_clamp_q <= out_clamp_d;
  end

  ptc_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (ram_wdata),
    .raddr_i (raddr_fin),
    .rdata_o (ram_rdata)
  );

  ptc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign out_valid_o  = out_valid_q;
  assign correction_o = out_corr_q;
  assign segment_o    = out_seg_q;
  assign clamped_o    = out_clamp_q;

`ifndef SYNTHESIS
  a_result_from_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_Q_DONE))
    else $error("result beat raised outside the query finish");

  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_LD_DIV))
    else $error("divider finished while the sequencer was not waiting");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q != S_IDLE))
    else $error("accepted beat left the sequencer idle");
`endif

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// testbench for piecewise_linear_thermo_correction_top: loads breakpoint tables and
// checks every query result against a behavioural copy of the table; uses ptc_pkg
`timescale 1ns / 1ps

module tb_top;
  import ptc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam longint      SLOPE_HI    = (64'sd1 <<< 55) - 1;
  localparam longint      SLOPE_LO    = -(64'sd1 <<< 55);
  localparam longint      QPART_LIM   = 64'sd1 <<< 40;

  typedef struct {
    logic signed [31:0] correction;
    logic [3:0]         segment;
    logic               clamped;
  } corr_result_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               command;
  logic [3:0]         entry_index;
  logic signed [15:0] load_temp;
  logic signed [31:0] load_correction;
  logic signed [15:0] query_temp;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] correction;
  logic [3:0]         segment;
  logic               clamped;

  // behavioural copy of the breakpoint table
  longint bp_temp [ENTRIES];
  longint bp_corr [ENTRIES];
  longint bp_slope[ENTRIES];

  corr_result_t pending_results[$];
  int unsigned  n_errors;
  int unsigned  n_loads;
  int unsigned  n_queries;
  int unsigned  n_checked;
  int unsigned  n_clamped;
  int unsigned  cycle_count;
  int unsigned  burst_left;
  bit           gaps_on;
  int unsigned  rx_count;
  int unsigned  rx_mode;

  piecewise_linear_thermo_correction_top uut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .command_i        (command),
    .entry_index_i    (entry_index),
    .load_temp_i      (load_temp),
    .load_correction_i(load_correction),
    .query_temp_i     (query_temp),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .correction_o     (correction),
    .segment_o        (segment),
    .clamped_o        (clamped)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic void store_breakpoint(int idx, longint t, longint c);
    longint dt;
    bp_temp[idx] = t;
    bp_corr[idx] = c;
    if (idx == 0) begin
      bp_slope[idx] = 0;
    end else begin
      dt = t - bp_temp[idx-1];
      if (dt == 0) bp_slope[idx] = 0;
      else bp_slope[idx] = clip(((c - bp_corr[idx-1]) * (64'sd1 <<< SLOPE_FRAC_BITS)) / dt,
                                SLOPE_LO, SLOPE_HI);
    end
  endfunction

  function automatic corr_result_t predict_correction(longint q);
    corr_result_t r;
    longint t, gap, sl, rpart, qpart, prod;
    int     seg;
    t = q;
    r.clamped = 1'b0;
    if (q > bp_temp[ENTRIES-1]) begin
      t = bp_temp[ENTRIES-1];
      r.clamped = 1'b1;
    end
    seg = 0;
    while (seg < ENTRIES - 1 && t > bp_temp[seg]) seg++;
    gap = bp_temp[seg] - t;
    if (gap < 0) gap = 0;
    sl = bp_slope[seg];
    rpart = sl & ((64'sd1 <<< SLOPE_FRAC_BITS) - 1);
    qpart = (sl - rpart) / (64'sd1 <<< SLOPE_FRAC_BITS);
    if (gap > 0) qpart = clip(qpart, -QPART_LIM, QPART_LIM);
    prod = qpart * gap + ((rpart * gap) >>> SLOPE_FRAC_BITS);
    r.correction = 32'(clip(bp_corr[seg] - prod, -64'sd2147483648, 64'sd2147483647));
    r.segment = 4'(seg);
    return r;
  endfunction

  // one input beat; valid stays up across a burst
  task automatic send_item(logic cmd, logic [3:0] idx, logic signed [15:0] lt,
                           logic signed [31:0] lc, logic signed [15:0] qt);
    @(negedge clk);
    in_valid        = 1'b1;
    command         = cmd;
    entry_index     = idx;
    load_temp       = lt;
    load_correction = lc;
    query_temp      = qt;
    do @(posedge clk); while (!in_ready);
    if (cmd == CMD_LOAD) begin
      store_breakpoint(idx, longint'(lt), longint'(lc));
      n_loads++;
    end else begin
      pending_results.push_back(predict_correction(longint'(qt)));
      n_queries++;
    end
    if (gaps_on) begin
      if (burst_left == 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
        burst_left = $urandom_range(1, 20);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic load_entry(int idx, int t, int c);
    send_item(CMD_LOAD, 4'(idx), 16'(t), 32'(c), 16'($urandom));
  endtask

  task automatic query_at(int t);
    send_item(CMD_QUERY, 4'($urandom), 16'($urandom), 32'($urandom), 16'(t));
  endtask

  // ascending table with a repeated temperature and correction extremes
  task automatic test_directed_table;
    int temps[ENTRIES] = '{-32768, -30000, -20000, -10000, -5000, -5000, -1000, 0,
                           1, 100, 2000, 8000, 15000, 20000, 25000, 30000};
    int corrs[ENTRIES] = '{32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, -100, 500,
                           32'h80000000, 32'h7fffffff, 32'h80000000, 12345, -12345,
                           0, 1, -1, 32'h7fffffff, 32'h80000000};
    gaps_on = 1'b0;
    for (int i = 0; i < ENTRIES; i++) load_entry(i, temps[i], corrs[i]);
    query_at(-32768);
    query_at(32767);
    query_at(30000);
    query_at(-5000);
    query_at(-25000);
    query_at(-15000);
    query_at(0);
    query_at(-3);
    query_at(22222);
  endtask

  // fresh sorted tables with random content, then queries and some stray loads
  task automatic test_random_tables;
    int t[ENTRIES];
    int tmp, span, base, nq;
    gaps_on = 1'b1;
    for (int round = 0; round < 23; round++) begin
      span = (round % 4 == 0) ? 64 : 65536;
      base = (span == 64) ? $urandom_range(0, 65472) - 32768 : -32768;
      for (int i = 0; i < ENTRIES; i++) t[i] = base + $urandom_range(0, span - 1);
      for (int i = 1; i < ENTRIES; i++)
        for (int j = i; j > 0 && t[j] < t[j-1]; j--) begin
          tmp = t[j]; t[j] = t[j-1]; t[j-1] = tmp;
        end
      if (round == 3) t[ENTRIES-1] = 32767;
      if (round == 5) t[0] = -32768;
      gaps_on = (round % 5 != 2);
      for (int i = 0; i < ENTRIES; i++) load_entry(i, t[i], int'($urandom));
      nq = $urandom_range(35, 50);
      for (int k = 0; k < nq; k++) begin
        case ($urandom_range(0, 9))
          0: load_entry($urandom_range(0, 15), int'($urandom), int'($urandom));
          1: query_at(t[$urandom_range(0, 15)] + $urandom_range(0, 2) - 1);
          2: query_at($urandom_range(0, 1) ? 32767 : -32768);
          3, 4: query_at(t[0] + $urandom_range(0, t[ENTRIES-1] - t[0]));
          default: query_at(int'($urandom));
        endcase
      end
    end
  endtask

  // receiver stall pattern: switches between modes on its own
  always @(negedge clk) begin
    rx_count++;
    if (rx_count % 256 == 0) rx_mode <= $urandom_range(0, 3);
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= (rx_count % 8 == 0);
      default: out_ready <= rx_count[4];
    endcase
  end

  always @(posedge clk) begin
    corr_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat corr=%0d seg=%0d clamped=%0b",
                 $time, correction, segment, clamped);
        n_errors++;
      end else begin
        exp_r = pending_results.pop_front();
        n_checked++;
        if (exp_r.clamped) n_clamped++;
        if (correction !== exp_r.correction) begin
          $display("%0t: correction expected %0d actual %0d", $time, exp_r.correction,
                   correction);
          n_errors++;
        end
        if (segment !== exp_r.segment) begin
          $display("%0t: segment expected %0d actual %0d", $time, exp_r.segment, segment);
          n_errors++;
        end
        if (clamped !== exp_r.clamped) begin
          $display("%0t: clamped expected %0b actual %0b", $time, exp_r.clamped, clamped);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned drain;
    rst_n = 1'b0;
    in_valid = 1'b0;
    command = CMD_LOAD;
    entry_index = '0;
    load_temp = '0;
    load_correction = '0;
    query_temp = '0;
    out_ready = 1'b0;
    rx_mode = 0;
    rx_count = 0;
    burst_left = 0;
    gaps_on = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_table();
    test_random_tables();
    @(negedge clk);
    in_valid = 1'b0;

    drain = 0;
    while (pending_results.size() != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (64) @(posedge clk);

    $display("covered %0d breakpoint loads and %0d queries, %0d results checked",
             n_loads, n_queries, n_checked);
    $display("%0d results clamped to the last breakpoint, %0d mismatches",
             n_clamped, n_errors);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/ptc_pkg.sv
src/ptc_ram.sv
src/ptc_div.sv
src/piecewise_linear_thermo_correction_top.sv
tb/tb_top.sv
